// ----- hw/rtl/mkld_pkg.sv -----
package mkld_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SYMBOLS_DEF     = 4;
  localparam int MESSAGE_LETTERS_DEF = 4;
  localparam int TIMER_BITS_DEF      = 16;

  // Configuration register indexes.
  localparam logic [1:0] REG_DOT_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_TOO_LONG      = 2'd1;
  localparam logic [1:0] REG_LETTER_GAP    = 2'd2;
  localparam logic [1:0] REG_LETTER_LIMIT  = 2'd3;

  localparam int CFG_BITS = 16;

  localparam logic [CFG_BITS-1:0] DOT_THRESHOLD_RST = 16'd250;
  localparam logic [CFG_BITS-1:0] TOO_LONG_RST      = 16'd700;
  localparam logic [CFG_BITS-1:0] LETTER_GAP_RST    = 16'd400;
  localparam logic [CFG_BITS-1:0] LETTER_LIMIT_RST  = 16'd4000;

  typedef logic [2:0] event_t;

  localparam event_t EV_LETTER         = 3'd0;
  localparam event_t EV_LETTER_TIMEOUT = 3'd1;
  localparam event_t EV_UNKNOWN        = 3'd2;
  localparam event_t EV_UNKNOWN_TIMEOUT = 3'd3;
  localparam event_t EV_PRESS_TOO_LONG = 3'd4;
  localparam event_t EV_TOO_MANY       = 3'd5;

  localparam int NUM_LETTERS = 26;

  // Morse table, A first: symbol count and pattern (dash = 1, first symbol in the MSB).
  localparam logic [2:0] MORSE_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
    3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  localparam logic [3:0] MORSE_CODE [NUM_LETTERS] = '{
    4'd1,  4'd8,  4'd10, 4'd4, 4'd0,  4'd2,  4'd6, 4'd0, 4'd0,
    4'd7,  4'd5,  4'd4,  4'd3, 4'd2,  4'd7,  4'd6, 4'd13, 4'd2,
    4'd0,  4'd1,  4'd1,  4'd1, 4'd3,  4'd9,  4'd11, 4'd12
  };

endpackage

// ----- hw/rtl/morse_key_letter_decoder.sv -----
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ---------------------------------------------
// key in    input      in_valid_i / in_ready_o   key_down_i
// result    output     out_valid_o / out_ready_i event_res_o, letter_o,
//                                                letters_in_message_o, message_full_o
// config    input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// For each key sample, the timers, the press classification and the
// letter table match are one combinational pass from the state registers into the
// result register, so a new item can be taken on every clock while in_ready_o is high.
// An item that yields a result loads the output register; the input side keeps
// accepting while that register is empty or being drained in the same cycle.
// Reset clears all timers, the symbol buffer and the letter count, and loads the
// register defaults.
module morse_key_letter_decoder #(
  parameter int MAX_SYMBOLS     = mkld_pkg::MAX_SYMBOLS_DEF,
  parameter int MESSAGE_LETTERS = mkld_pkg::MESSAGE_LETTERS_DEF,
  parameter int TIMER_BITS      = mkld_pkg::TIMER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        key_down_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [4:0]  letter_o,
  output logic [2:0]  letters_in_message_o,
  output logic        message_full_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import mkld_pkg::*;

  localparam int CntW = $clog2(MAX_SYMBOLS + 1);
  localparam int LcW  = $clog2(MESSAGE_LETTERS + 1);
  localparam int CmpW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
  localparam logic [TIMER_BITS-1:0] TMax = {TIMER_BITS{1'b1}};

  // Configuration registers.
  logic [CFG_BITS-1:0] dot_thr_q, too_long_q, gap_lim_q, win_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_thr_q  <= DOT_THRESHOLD_RST;
      too_long_q <= TOO_LONG_RST;
      gap_lim_q  <= LETTER_GAP_RST;
      win_lim_q  <= LETTER_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DOT_THRESHOLD: dot_thr_q  <= cfg_data_i;
        REG_TOO_LONG:      too_long_q <= cfg_data_i;
        REG_LETTER_GAP:    gap_lim_q  <= cfg_data_i;
        REG_LETTER_LIMIT:  win_lim_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decoder state.
  logic                  was_down_q, was_down_d;
  logic [TIMER_BITS-1:0] press_q, press_d;
  logic [TIMER_BITS-1:0] gap_q, gap_d;
  logic                  armed_q, armed_d;
  logic [TIMER_BITS-1:0] win_q, win_d;
  logic                  running_q, running_d;
  logic [MAX_SYMBOLS-1:0] pat_q, pat_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [LcW-1:0]        lc_q, lc_d;

  // Output register.
  logic       out_valid_q, out_valid_d;
  event_t     ev_q, ev_d;
  logic [4:0] letter_q, letter_d;
  logic [2:0] lim_q, lim_d;
  logic       full_q, full_d;

  logic in_acc;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == TMax) ? v : v + 1'b1;
  endfunction

  // Letter table match on the pattern that is about to be decoded.
  logic [MAX_SYMBOLS-1:0] dec_pat;
  logic [CntW-1:0]        dec_cnt;
  logic                   found;
  logic [4:0]             found_idx;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < NUM_LETTERS; i++) begin
      if (!found && 8'(dec_cnt) == 8'(MORSE_LEN[i]) && 8'(dec_pat) == 8'(MORSE_CODE[i])) begin
        found     = 1'b1;
        found_idx = 5'(i);
      end
    end
  end

  logic            rel_pat_bit;
  logic [CntW-1:0] rel_cnt;
  logic [LcW-1:0]  lc_inc;
  logic            do_decode, timed_out, have_res;

  always_comb begin
    was_down_d = was_down_q;
    press_d    = press_q;
    gap_d      = gap_q;
    armed_d    = armed_q;
    win_d      = win_q;
    running_d  = running_q;
    pat_d      = pat_q;
    cnt_d      = cnt_q;
    lc_d       = lc_q;
    ev_d       = ev_q;
    letter_d   = letter_q;
    lim_d      = lim_q;
    full_d     = full_q;
    dec_pat    = pat_q;
    dec_cnt    = cnt_q;
    do_decode  = 1'b0;
    timed_out  = 1'b0;
    have_res   = 1'b0;
    lc_inc     = lc_q + 1'b1;
    rel_pat_bit = !(CmpW'(press_q) < CmpW'(dot_thr_q));
    rel_cnt    = cnt_q + 1'b1;

    if (in_acc) begin
      was_down_d = key_down_i;
      if (running_q) begin
        win_d = sat_inc(win_q);
      end
      if (key_down_i) begin
        if (!was_down_q) begin
          press_d = TIMER_BITS'(1);
          armed_d = 1'b0;
          gap_d   = '0;
          if (cnt_q == '0) begin
            win_d     = '0;
            running_d = 1'b1;
          end
        end else begin
          press_d = sat_inc(press_q);
        end
      end else if (was_down_q) begin
        // Release: classify the press just ended.
        if (cnt_q >= CntW'(MAX_SYMBOLS)) begin
          have_res = 1'b1;
          ev_d     = EV_TOO_MANY;
        end else if (CmpW'(press_q) > CmpW'(too_long_q)) begin
          have_res = 1'b1;
          ev_d     = EV_PRESS_TOO_LONG;
        end else begin
          pat_d   = {pat_q[MAX_SYMBOLS-2:0], rel_pat_bit};
          cnt_d   = rel_cnt;
          armed_d = 1'b1;
          gap_d   = '0;
          dec_pat = pat_d;
          dec_cnt = rel_cnt;
          if (running_q && CmpW'(win_d) > CmpW'(win_lim_q)) begin
            do_decode = 1'b1;
            timed_out = 1'b1;
          end
        end
        if (have_res) begin
          letter_d = '0;
          lim_d    = 3'(lc_q);
          full_d   = 1'b0;
        end
      end else begin
        // Idle tick: window first, then the letter gap.
        if (armed_q) begin
          gap_d = sat_inc(gap_q);
        end
        if (running_q && cnt_q != '0 && CmpW'(win_d) > CmpW'(win_lim_q)) begin
          do_decode = 1'b1;
          timed_out = 1'b1;
        end else if (armed_q && cnt_q != '0 && CmpW'(gap_d) > CmpW'(gap_lim_q)) begin
          do_decode = 1'b1;
        end
      end

      if (do_decode) begin
        have_res = 1'b1;
        if (found) begin
          ev_d     = timed_out ? EV_LETTER_TIMEOUT : EV_LETTER;
          letter_d = found_idx;
          lim_d    = 3'(lc_inc);
          if (lc_inc == LcW'(MESSAGE_LETTERS)) begin
            full_d = 1'b1;
            lc_d   = '0;
          end else begin
            full_d = 1'b0;
            lc_d   = lc_inc;
          end
        end else begin
          ev_d     = timed_out ? EV_UNKNOWN_TIMEOUT : EV_UNKNOWN;
          letter_d = '0;
          lim_d    = 3'(lc_q);
          full_d   = 1'b0;
        end
      end

      // Errors and decodes both empty the symbol buffer.
      if (have_res) begin
        pat_d     = '0;
        cnt_d     = '0;
        running_d = 1'b0;
        win_d     = '0;
        armed_d   = 1'b0;
        gap_d     = '0;
      end
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (have_res) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q  <= 1'b0;
      press_q     <= '0;
      gap_q       <= '0;
      armed_q     <= 1'b0;
      win_q       <= '0;
      running_q   <= 1'b0;
      pat_q       <= '0;
      cnt_q       <= '0;
      lc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      was_down_q  <= was_down_d;
      press_q     <= press_d;
      gap_q       <= gap_d;
      armed_q     <= armed_d;
      win_q       <= win_d;
      running_q   <= running_d;
      pat_q       <= pat_d;
      cnt_q       <= cnt_d;
      lc_q        <= lc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    ev_q     <= ev_d;
    letter_q <= letter_d;
    lim_q    <= lim_d;
    full_q   <= full_d;
  end

  assign out_valid_o          = out_valid_q;
  assign event_res_o          = ev_q;
  assign letter_o             = letter_q;
  assign letters_in_message_o = lim_q;
  assign message_full_o       = full_q;

  // A buffered symbol always belongs to a running letter window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 |-> running_q)
    else $error("symbols buffered without a running window");

  // The buffer never holds more than the symbol limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_SYMBOLS))
    else $error("symbol count beyond limit");

  // The stored letter count stays below the message length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lc_q) < MESSAGE_LETTERS)
    else $error("letter count did not wrap");

  // Only a decoded letter can complete a message.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && full_q |-> (ev_q == EV_LETTER || ev_q == EV_LETTER_TIMEOUT))
    else $error("message full flagged on a non-letter event");

endmodule
